// File: design/rldd_pkg.sv
`default_nettype none

package rldd_pkg;

  // byte codes of the compressed format
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // decimal radix of the repeat count
  localparam int unsigned RADIX = 10;

  // default longest legal run
  localparam int unsigned MAX_RUN_DEF = 63;

  // where the parser stands in the symbol/count grammar
  typedef enum logic [1:0] {
    PH_SYM    = 2'd0,
    PH_FIRST  = 2'd1,
    PH_DIGITS = 2'd2
  } phase_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EXEC = 2'd1,
    ST_EMIT = 2'd2,
    ST_FIN  = 2'd3
  } state_t;

  // operations of the shared count unit
  typedef enum logic {
    ALU_ACC = 1'b0,
    ALU_DEC = 1'b1
  } alu_op_t;

endpackage

`default_nettype wire

// File: design/rldd_if.sv
`default_nettype none

interface rldd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       stream_end;

  modport source (output valid, output in_byte, output stream_end, input ready);
  modport sink (input valid, input in_byte, input stream_end, output ready);
endinterface

interface rldd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       stream_done;
  logic       decode_error;
  logic       last;

  modport source (
    output valid, output out_byte, output byte_valid, output stream_done,
    output decode_error, output last, input ready
  );
  modport sink (
    input valid, input out_byte, input byte_valid, input stream_done,
    input decode_error, input last, output ready
  );
endinterface

`default_nettype wire

// File: design/run_length_decimal_decoder_core.sv
`default_nettype none

// run-length decoder for symbol + decimal count streams
// in_chan: one beat per compressed byte; a beat with stream_end set closes the
//   stream and carries no byte
// out_chan: one beat per decoded byte, plus one status beat (stream_done) for
//   the end beat; decode_error on that beat means the stream was malformed and
//   every byte already sent for it must be dropped; last marks the final beat
//   caused by one input beat
// timing: a beat is registered when taken and decided in the next cycle; a byte that
//   only starts or extends a run, a lone space and an end beat with no run to
//   flush are finished there; a byte that closes a run first counts the run
//   down through the shared count unit, one output beat per count, and then
//   finishes the item (new symbol, space or status beat)
// in_chan.ready is high only while the sequencer is idle
// output sits in a single register; while the receiver stalls the sequencer
//   waits on it, and no further input beat is taken until the item is done
// reset (rst, synchronous) returns the parser to "expecting a symbol", clears
//   the sticky error and drops any pending output beat
// after the end beat all parser state is back at its reset values
module run_length_decimal_decoder_core
  import rldd_pkg::*;
#(
  parameter int unsigned MAX_RUN = MAX_RUN_DEF,
  localparam int unsigned CW = $clog2(MAX_RUN + 1)
) (
  input wire logic  clk,
  input wire logic  rst,
  rldd_in_if.sink   in_chan,
  rldd_out_if.source out_chan
);

  // sequencer and parser state
  state_t        state, state_next;
  phase_t        phase, phase_next;
  logic [7:0]    held_symbol, held_next;
  logic [CW-1:0] run_count, count_next;
  logic          error_seen, err_next;

  // input beat under work
  logic [7:0]    cur_byte;
  logic          cur_end;

  // output register
  logic          out_valid;
  logic [7:0]    o_byte;
  logic          o_bvalid, o_done, o_err, o_last;

  // next output beat
  logic          load;
  logic [7:0]    ld_byte;
  logic          ld_bvalid, ld_done, ld_err, ld_last;

  // shared count unit
  alu_op_t       alu_op;
  logic [CW-1:0] alu_cnt, alu_value;
  logic          alu_over;
  logic [3:0]    digit_val;

  logic          is_digit, is_space, tail_out, can_load, finish, err_fin, in_take;

  assign in_chan.ready = (state == ST_IDLE);
  assign in_take       = in_chan.valid && in_chan.ready;

  assign is_digit  = (cur_byte >= CH_ZERO) && (cur_byte <= CH_NINE);
  assign is_space  = (cur_byte == CH_SPACE);
  assign digit_val = 4'(cur_byte - CH_ZERO);
  // the end beat always closes with a status beat, a space always stands for itself
  assign tail_out  = cur_end || is_space;
  // output register free, or emptied this cycle
  assign can_load  = !out_valid || out_chan.ready;
  // symbol still waiting for its first digit at end of stream is an error
  assign err_fin   = error_seen || (cur_end && (phase == PH_FIRST));

  // first digit accumulates onto zero, later digits onto the running count
  assign alu_cnt = (state == ST_EXEC && phase == PH_FIRST) ? '0 : run_count;

  rldd_alu #(
    .MAX_RUN (MAX_RUN)
  ) u_alu (
    .op    (alu_op),
    .count (alu_cnt),
    .digit (digit_val),
    .value (alu_value),
    .over  (alu_over)
  );

  always_comb begin
    state_next = state;
    phase_next = phase;
    held_next  = held_symbol;
    count_next = run_count;
    err_next   = error_seen;
    load       = 1'b0;
    ld_byte    = '0;
    ld_bvalid  = 1'b0;
    ld_done    = 1'b0;
    ld_err     = 1'b0;
    ld_last    = 1'b0;
    alu_op     = ALU_ACC;
    finish     = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (in_take) begin
          state_next = ST_EXEC;
        end
      end

      ST_EXEC: begin
        if (cur_end) begin
          // flush a pending run before the status beat
          if (!error_seen && phase == PH_DIGITS && run_count != '0) begin
            state_next = ST_EMIT;
          end else begin
            finish = 1'b1;
          end
        end else if (error_seen) begin
          // bytes after an error are dropped until the end beat
          state_next = ST_IDLE;
        end else begin
          unique case (phase)
            PH_SYM: begin
              finish = 1'b1;
            end
            PH_FIRST: begin
              if (is_digit && !alu_over) begin
                count_next = alu_value;
                phase_next = PH_DIGITS;
              end else begin
                err_next = 1'b1;
              end
              state_next = ST_IDLE;
            end
            PH_DIGITS: begin
              if (is_digit) begin
                if (alu_over) begin
                  err_next = 1'b1;
                end else begin
                  count_next = alu_value;
                end
                state_next = ST_IDLE;
              end else if (run_count != '0) begin
                state_next = ST_EMIT;
              end else begin
                finish = 1'b1;
              end
            end
            default: begin
              state_next = ST_IDLE;
            end
          endcase
        end
      end

      ST_EMIT: begin
        // count the run down, one byte per beat
        alu_op = ALU_DEC;
        if (can_load) begin
          load       = 1'b1;
          ld_byte    = held_symbol;
          ld_bvalid  = 1'b1;
          ld_last    = (run_count == CW'(1)) && !tail_out;
          count_next = alu_value;
          if (run_count == CW'(1)) begin
            state_next = ST_FIN;
          end
        end
      end

      ST_FIN: begin
        finish = 1'b1;
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // end-of-stream status, a space, or a new symbol that opens a run
    if (finish) begin
      if (tail_out) begin
        if (can_load) begin
          load       = 1'b1;
          ld_last    = 1'b1;
          state_next = ST_IDLE;
          phase_next = PH_SYM;
          if (cur_end) begin
            ld_done    = 1'b1;
            ld_err     = err_fin;
            held_next  = '0;
            count_next = '0;
            err_next   = 1'b0;
          end else begin
            ld_byte   = CH_SPACE;
            ld_bvalid = 1'b1;
          end
        end
      end else begin
        held_next  = cur_byte;
        count_next = '0;
        phase_next = PH_FIRST;
        state_next = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      phase       <= PH_SYM;
      held_symbol <= '0;
      run_count   <= '0;
      error_seen  <= 1'b0;
    end else begin
      state       <= state_next;
      phase       <= phase_next;
      held_symbol <= held_next;
      run_count   <= count_next;
      error_seen  <= err_next;
    end
  end

  // captured input beat
  always_ff @(posedge clk) begin
    if (in_take) begin
      cur_byte <= in_chan.in_byte;
      cur_end  <= in_chan.stream_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      o_byte   <= ld_byte;
      o_bvalid <= ld_bvalid;
      o_done   <= ld_done;
      o_err    <= ld_err;
      o_last   <= ld_last;
    end
  end

  assign out_chan.valid        = out_valid;
  assign out_chan.out_byte     = o_byte;
  assign out_chan.byte_valid   = o_bvalid;
  assign out_chan.stream_done  = o_done;
  assign out_chan.decode_error = o_err;
  assign out_chan.last         = o_last;

  // a run being counted out is never empty
  a_emit_nonzero : assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT |-> run_count != '0)
    else $error("run countdown entered with zero count");

  // the held count never passes the limit
  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    run_count <= CW'(MAX_RUN))
    else $error("run count above limit");

  // once an error is seen no more data bytes go out
  a_no_data_after_err : assert property (@(posedge clk) disable iff (rst)
    load && ld_bvalid |-> !error_seen)
    else $error("data beat after decode error");

  // a status beat is the closing beat and carries no byte
  a_status_last : assert property (@(posedge clk) disable iff (rst)
    out_valid && o_done |-> o_last && !o_bvalid)
    else $error("malformed status beat");

endmodule

`default_nettype wire

// File: design/rldd_alu.sv
`default_nettype none

module rldd_alu
  import rldd_pkg::*;
#(
  parameter int unsigned MAX_RUN = MAX_RUN_DEF,
  localparam int unsigned CW = $clog2(MAX_RUN + 1)
) (
  input  wire alu_op_t         op,
  input  wire logic [CW-1:0]   count,
  input  wire logic [3:0]      digit,
  output logic      [CW-1:0]   value,
  output logic                 over
);

  localparam int unsigned WW = CW + 4;

  logic [WW-1:0] acc;

  // count * 10 + digit, wide enough for any count and digit
  assign acc = WW'(count) * WW'(RADIX) + WW'(digit);

  always_comb begin
    unique case (op)
      ALU_ACC: begin
        value = acc[CW-1:0];
        over  = (acc > WW'(MAX_RUN));
      end
      ALU_DEC: begin
        value = count - CW'(1);
        over  = 1'b0;
      end
      default: begin
        value = count;
        over  = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: verif/tb_run_length_decimal_decoder_core.sv
`default_nettype none

module tb_run_length_decimal_decoder_core;
  import rldd_pkg::*;

  // one decoded output beat as the receiver sees it
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       stream_done;
    logic       decode_error;
    logic       last;
  } dec_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rldd_in_if  in_chan ();
  rldd_out_if out_chan ();

  run_length_decimal_decoder_core dut (
    .clk      (clk),
    .rst      (rst),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always #5 clk = ~clk;

  // decoded beats still owed by the block, oldest first
  dec_beat_t decoded_q[$];

  // parser state of the predictor
  phase_t      parse_ph = PH_SYM;
  logic [7:0]  held_sym = 8'h00;
  int unsigned run_len  = 0;
  logic        err_seen = 1'b0;

  // bookkeeping
  int fail_count  = 0;
  int beats_in    = 0;
  int live_beats  = 0;
  int beats_out   = 0;
  int streams     = 0;
  int bad_streams = 0;

  // sender burst shaping
  int burst_left = 0;

  // receiver stall pattern and long hold-off
  int         hold_left = 0;
  logic [7:0] ready_pat = 8'hFF;
  int         pat_age   = 0;
  int         pat_pos   = 0;

  dec_beat_t got_beat;
  dec_beat_t want_beat;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------
  function automatic void push_beat(input logic [7:0] b, input logic v, input logic d,
                                    input logic er);
    dec_beat_t nb;
    nb.out_byte     = b;
    nb.byte_valid   = v;
    nb.stream_done  = d;
    nb.decode_error = er;
    nb.last         = 1'b0;
    decoded_q.push_back(nb);
  endfunction

  // emit the pending run and go back to expecting a symbol
  function automatic void flush_run();
    for (int n = 0; n < run_len; n++) push_beat(held_sym, 1'b1, 1'b0, 1'b0);
    run_len  = 0;
    parse_ph = PH_SYM;
  endfunction

  // a space stands for itself, anything else opens a run
  function automatic void open_symbol(input logic [7:0] b);
    if (b == CH_SPACE) begin
      push_beat(b, 1'b1, 1'b0, 1'b0);
      parse_ph = PH_SYM;
    end else begin
      held_sym = b;
      run_len  = 0;
      parse_ph = PH_FIRST;
    end
  endfunction

  // works out every output beat that one accepted input beat causes
  function automatic void decode_in_beat(input logic [7:0] b, input logic e);
    int unsigned base;
    int unsigned digit_val;
    logic        is_digit;
    dec_beat_t   tail;
    base      = decoded_q.size();
    is_digit  = (b >= CH_ZERO) && (b <= CH_NINE);
    digit_val = int'(8'(b - CH_ZERO));
    if (e) begin
      live_beats++;
      if (!err_seen) begin
        // a symbol still waiting for its count is malformed
        if (parse_ph == PH_FIRST) err_seen = 1'b1;
        else if (parse_ph == PH_DIGITS) flush_run();
      end
      push_beat(8'h00, 1'b0, 1'b1, err_seen);
      streams++;
      if (err_seen) bad_streams++;
      parse_ph = PH_SYM;
      held_sym = 8'h00;
      run_len  = 0;
      err_seen = 1'b0;
    end else if (!err_seen) begin
      live_beats++;
      case (parse_ph)
        PH_FIRST: begin
          if (is_digit) begin
            run_len  = digit_val;
            parse_ph = PH_DIGITS;
          end else begin
            err_seen = 1'b1;
          end
        end
        PH_DIGITS: begin
          if (is_digit) begin
            // flagged, never saturated
            if (run_len * RADIX + digit_val > MAX_RUN_DEF) err_seen = 1'b1;
            else run_len = run_len * RADIX + digit_val;
          end else begin
            flush_run();
            open_symbol(b);
          end
        end
        default: open_symbol(b);
      endcase
    end
    if (decoded_q.size() > base) begin
      tail      = decoded_q.pop_back();
      tail.last = 1'b1;
      decoded_q.push_back(tail);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // sender: drive at the falling edge, accept at the rising edge
  // ---------------------------------------------------------------------------
  task automatic send_beat(input logic [7:0] b, input logic e);
    @(negedge clk);
    in_chan.valid      <= 1'b1;
    in_chan.in_byte    <= b;
    in_chan.stream_end <= e;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    decode_in_beat(b, e);
    beats_in++;
    // bursts of random length, random gaps, sometimes long gap-free stretches
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      repeat ($urandom_range(0, 6)) begin
        @(negedge clk);
        in_chan.valid <= 1'b0;
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
    end
  endtask

  // decimal count, optionally with leading zeros
  task automatic send_count(input int unsigned n, input int unsigned zeros);
    repeat (zeros) send_beat(CH_ZERO, 1'b0);
    if (n >= 100) send_beat(CH_ZERO + 8'(n / 100), 1'b0);
    if (n >= 10) send_beat(CH_ZERO + 8'((n / 10) % 10), 1'b0);
    send_beat(CH_ZERO + 8'(n % 10), 1'b0);
  endtask

  // mostly well-formed stream with random symbols and counts, some broken ones
  task automatic send_random_stream();
    int unsigned ntok;
    int unsigned pick;
    logic [7:0]  sym;
    ntok = $urandom_range(1, 6);
    repeat (ntok) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        send_beat(CH_SPACE, 1'b0);
      end else begin
        sym = 8'($urandom_range(0, 255));
        send_beat(sym, 1'b0);
        pick = $urandom_range(0, 99);
        // below 4: no count at all, the next token decides what happens
        if (sym != CH_SPACE && pick >= 4) begin
          if (pick < 8) send_count($urandom_range(64, 999), 0);
          else if (pick < 60)
            send_count($urandom_range(0, 9), ($urandom_range(0, 9) == 0) ? 1 : 0);
          else
            send_count($urandom_range(0, 63),
                       ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0);
        end
      end
      // stray noise byte
      if ($urandom_range(0, 49) == 0) send_beat(8'($urandom_range(0, 255)), 1'b0);
    end
    send_beat(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // receiver: own stall pattern, plus a long hold-off on request
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_chan.ready <= 1'b0;
    end else begin
      if (pat_age == 0) begin
        case ($urandom_range(0, 3))
          0: ready_pat = 8'hFF;
          1: ready_pat = 8'h11;
          default: ready_pat = 8'($urandom_range(1, 255));
        endcase
        pat_age = $urandom_range(8, 48);
      end
      pat_age--;
      out_chan.ready <= ready_pat[pat_pos[2:0]];
      pat_pos = (pat_pos + 1) % 8;
    end
  end

  // ---------------------------------------------------------------------------
  // checker: every accepted output beat against the oldest prediction
  // ---------------------------------------------------------------------------
  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_chan.valid && out_chan.ready) begin
      beats_out++;
      got_beat.out_byte     = out_chan.out_byte;
      got_beat.byte_valid   = out_chan.byte_valid;
      got_beat.stream_done  = out_chan.stream_done;
      got_beat.decode_error = out_chan.decode_error;
      got_beat.last         = out_chan.last;
      if (decoded_q.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual byte %0d valid %0b done %0b",
                 $time, got_beat.out_byte, got_beat.byte_valid, got_beat.stream_done);
        fail_count++;
      end else begin
        want_beat = decoded_q.pop_front();
        check_field("out_byte", want_beat.out_byte, got_beat.out_byte);
        check_field("byte_valid", want_beat.byte_valid, got_beat.byte_valid);
        check_field("stream_done", want_beat.stream_done, got_beat.stream_done);
        check_field("decode_error", want_beat.decode_error, got_beat.decode_error);
        check_field("last", want_beat.last, got_beat.last);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // plain runs, space, digit as symbol, extreme bytes, longest run, zero count
  task automatic test_directed_runs();
    send_beat("x", 1'b0);
    send_beat("3", 1'b0);
    send_beat(CH_SPACE, 1'b0);
    send_beat(CH_ZERO, 1'b0);
    send_beat("7", 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat("6", 1'b0);
    send_beat("3", 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(CH_ZERO, 1'b0);
    send_beat(8'hFF, 1'b1);
  endtask

  // non-digit after a symbol, later bytes ignored; symbol right before end
  task automatic test_missing_count();
    send_beat("a", 1'b0);
    send_beat("Z", 1'b0);
    send_beat("q", 1'b0);
    send_beat(8'h00, 1'b1);
    send_beat("b", 1'b0);
    send_beat(8'h55, 1'b1);
  endtask

  // count one past the longest run
  task automatic test_count_overflow();
    send_beat("c", 1'b0);
    send_beat("6", 1'b0);
    send_beat("4", 1'b0);
    send_beat(8'hAA, 1'b1);
  endtask

  // end beat with nothing before it
  task automatic test_empty_stream();
    send_beat(8'h00, 1'b1);
  endtask

  // receiver holds off for a long stretch while streams keep coming
  task automatic test_backpressure();
    hold_left = 300;
    repeat (3) send_random_stream();
  endtask

  // random streams until the total number of input beats reaches the target
  task automatic test_random_streams(input int target);
    while (beats_in < target) send_random_stream();
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int drain;
    in_chan.valid      = 1'b0;
    in_chan.in_byte    = 8'h00;
    in_chan.stream_end = 1'b0;
    out_chan.ready     = 1'b0;
    rst                = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_runs();
    test_missing_count();
    test_count_overflow();
    test_empty_stream();
    test_backpressure();
    test_random_streams(260);

    @(negedge clk);
    in_chan.valid <= 1'b0;

    // wait for the owed beats, then a little longer for strays
    drain = 0;
    while (decoded_q.size() != 0 && drain < 200000) begin
      @(posedge clk);
      drain++;
    end
    repeat (80) @(posedge clk);
    if (decoded_q.size() != 0) begin
      $display("%0t: %0d expected beats never arrived", $time, decoded_q.size());
      fail_count++;
    end

    $display("run: %0d input beats (%0d decoded), %0d output beats checked", beats_in,
             live_beats, beats_out);
    $display("run: %0d streams, %0d of them malformed, %0d mismatches", streams,
             bad_streams, fail_count);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10000000;
    $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
design/rldd_pkg.sv
design/rldd_if.sv
design/rldd_alu.sv
design/run_length_decimal_decoder_core.sv
verif/tb_run_length_decimal_decoder_core.sv
